FILE: rtl/crc_codeword_packer_defines.svh
// Assertion macros shared by the checker of the CRC codeword packer.
`ifndef CRC_CODEWORD_PACKER_DEFINES_SVH
`define CRC_CODEWORD_PACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define CCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define CCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ccp_pkg.sv
// Shared types and constants of the CRC codeword packer.
package ccp_pkg;

  localparam int unsigned DEF_MAX_GEN_BITS = 16;
  localparam int unsigned DEF_COUNT_BITS   = 24;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned NIBBLE_BITS = 4;
  localparam int unsigned POLY_W      = 16;
  localparam int unsigned GLEN_W      = 5;

  typedef enum logic [1:0] {
    CFG_POLY  = 2'd0,
    CFG_GLEN  = 2'd1,
    CFG_MODE  = 2'd2,
    CFG_TOTAL = 2'd3
  } cfg_idx_e;

  localparam logic MODE_NIBBLE = 1'b0;
  localparam logic MODE_BYTE   = 1'b1;

  // Only the low three bits of the message length matter for the pad count.
  typedef struct packed {
    logic [POLY_W-1:0] poly;
    logic [GLEN_W-1:0] glen;
    logic              mode;
    logic [2:0]        total_lo;
  } cfg_t;

  localparam logic [POLY_W-1:0] RST_POLY = 16'd13;
  localparam logic [GLEN_W-1:0] RST_GLEN = 5'd4;

endpackage

FILE: rtl/crc_codeword_packer.sv
// Top level of the CRC codeword packer with a programmable generator.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | data_byte_i
//   out     | output    | out_valid_o/out_stall_i | out_byte_o, last_of_run_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// For each input byte the back end first merges the item into its bit buffer and
// then sends the output bytes; the header leaves during the merge and adds no step.
// The front end classifies in the accept cycle and a two-entry queue decouples it.
// Reset is asynchronous; it clears control state and loads register defaults.
// out_stall_i holds the output register; in_stall_o rises when the queue is full.
module crc_codeword_packer import ccp_pkg::*; #(
  parameter int unsigned MAX_GEN_BITS = DEF_MAX_GEN_BITS,
  parameter int unsigned COUNT_BITS   = DEF_COUNT_BITS,
  localparam int unsigned CFG_W  = (COUNT_BITS > POLY_W) ? COUNT_BITS : POLY_W,
  localparam int unsigned R_W    = MAX_GEN_BITS - 1,
  localparam int unsigned BW     = 8 + 2 * R_W,
  localparam int unsigned LEN_W  = $clog2(BW + 8),
  localparam int unsigned ITEM_W = 1 + 3 + LEN_W + BW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cfg_t              cfg_q, cfg_d;
  logic              q_full, q_valid, q_pop, take;
  logic [ITEM_W-1:0] item, q_item;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign take        = in_valid_i && !q_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POLY:  cfg_d.poly     = cfg_data_i[POLY_W-1:0];
        CFG_GLEN:  cfg_d.glen     = cfg_data_i[GLEN_W-1:0];
        CFG_MODE:  cfg_d.mode     = cfg_data_i[0];
        CFG_TOTAL: cfg_d.total_lo = cfg_data_i[2:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly     <= RST_POLY;
      cfg_q.glen     <= RST_GLEN;
      cfg_q.mode     <= MODE_BYTE;
      cfg_q.total_lo <= 3'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ccp_front #(.MAX_GEN_BITS(MAX_GEN_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .item_o      (item)
  );

  ccp_queue #(.WIDTH(ITEM_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  ccp_back #(.MAX_GEN_BITS(MAX_GEN_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

FILE: rtl/ccp_front.sv
// Front end: computes CRC remainders and forms one bit-stream item per byte.
module ccp_front import ccp_pkg::*; #(
  parameter int unsigned MAX_GEN_BITS = DEF_MAX_GEN_BITS,
  localparam int unsigned R_W    = MAX_GEN_BITS - 1,
  localparam int unsigned RI_W   = $clog2(MAX_GEN_BITS),
  localparam int unsigned BW     = 8 + 2 * R_W,
  localparam int unsigned LEN_W  = $clog2(BW + 8),
  localparam int unsigned ITEM_W = 1 + 3 + LEN_W + BW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  output logic [ITEM_W-1:0] item_o
);

  logic              hdr_sent_q, hdr_sent_d;
  logic [5:0]        glen_e, eff_len, r6;
  logic [RI_W-1:0]   r;
  logic [R_W-1:0]    mask, poly_r;
  logic [R_W+POLY_W-1:0] poly_w;
  logic [R_W-1:0]    rem_a, rem_b;
  logic [2:0]        cw_bits3, words3, pad;
  logic [5:0]        prod;
  logic [BW-1:0]     cw_a, cw_b, bits;
  logic [LEN_W-1:0]  len;
  logic              hdr;

  // Direct-form division: gives dataword * x^r mod g after the data bits alone.
  function automatic logic [R_W-1:0] crc_rem(input logic [7:0] word, input logic nib,
                                             input logic [R_W-1:0] poly,
                                             input logic [R_W-1:0] msk,
                                             input logic [RI_W-1:0] rr);
    logic [R_W-1:0] rem;
    logic [7:0]     w;
    logic           fb;
    rem = '0;
    w   = nib ? {word[3:0], 4'b0000} : word;
    for (int i = 0; i < 8; i++) begin
      if (!nib || i < 4) begin
        fb  = rem[rr - 1'b1] ^ w[7-i];
        rem = (rem << 1) & msk;
        if (fb) begin
          rem = rem ^ poly;
        end
      end
    end
    return rem;
  endfunction

  always_comb begin
    glen_e = 6'(cfg_i.glen);
    if (glen_e < 6'd2) begin
      eff_len = 6'd2;
    end else if (glen_e > 6'(MAX_GEN_BITS)) begin
      eff_len = 6'(MAX_GEN_BITS);
    end else begin
      eff_len = glen_e;
    end
    r6     = eff_len - 6'd1;
    r      = r6[RI_W-1:0];
    mask   = {R_W{1'b1}} >> (RI_W'(R_W) - r);
    poly_w = (R_W + POLY_W)'(cfg_i.poly);
    poly_r = poly_w[R_W-1:0] & mask;
  end

  always_comb begin
    if (cfg_i.mode == MODE_BYTE) begin
      rem_a = crc_rem(data_byte_i, 1'b0, poly_r, mask, r);
    end else begin
      rem_a = crc_rem({4'b0000, data_byte_i[7:4]}, 1'b1, poly_r, mask, r);
    end
    rem_b = crc_rem({4'b0000, data_byte_i[3:0]}, 1'b1, poly_r, mask, r);
  end

  // Codewords are kept right-aligned; leading pad zeros only add to the length.
  always_comb begin
    hdr = !hdr_sent_q;
    if (cfg_i.mode == MODE_BYTE) begin
      cw_a = (BW'(data_byte_i) << r) | BW'(rem_a);
      cw_b = '0;
      bits = cw_a;
      len  = LEN_W'(BYTE_BITS) + LEN_W'(r);
    end else begin
      cw_a = (BW'(data_byte_i[7:4]) << r) | BW'(rem_a);
      cw_b = (BW'(data_byte_i[3:0]) << r) | BW'(rem_b);
      bits = (cw_a << (LEN_W'(NIBBLE_BITS) + LEN_W'(r))) | cw_b;
      len  = LEN_W'(BYTE_BITS) + LEN_W'(r) + LEN_W'(r);
    end
    cw_bits3 = ((cfg_i.mode == MODE_BYTE) ? 3'(BYTE_BITS) : 3'(NIBBLE_BITS)) + r6[2:0];
    words3   = (cfg_i.mode == MODE_BYTE) ? cfg_i.total_lo : {cfg_i.total_lo[1:0], 1'b0};
    prod     = 6'(cw_bits3) * 6'(words3);
    pad      = 3'd0 - prod[2:0];
    if (hdr) begin
      len = len + LEN_W'(pad);
    end
    item_o = {hdr, pad, len, bits};
  end

  always_comb begin
    hdr_sent_d = hdr_sent_q | take_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_sent_q <= 1'b0;
    end else begin
      hdr_sent_q <= hdr_sent_d;
    end
  end

endmodule

FILE: rtl/ccp_queue.sv
// Two-entry queue between the front end and the packing back end.
module ccp_queue import ccp_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/ccp_back.sv
// Back end: merges stream items into a bit buffer and sends bytes MSB first.
module ccp_back import ccp_pkg::*; #(
  parameter int unsigned MAX_GEN_BITS = DEF_MAX_GEN_BITS,
  localparam int unsigned R_W    = MAX_GEN_BITS - 1,
  localparam int unsigned BW     = 8 + 2 * R_W,
  localparam int unsigned LEN_W  = $clog2(BW + 8),
  localparam int unsigned ITEM_W = 1 + 3 + LEN_W + BW,
  localparam int unsigned W      = BW + 14,
  localparam int unsigned AL_W   = $clog2(W + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  logic [ITEM_W-1:0] q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o
);

  logic [W-1:0]     acc_q, acc_d, shifted;
  logic [AL_W-1:0]  acc_len_q, acc_len_d, left;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             slot_free, emit;
  logic             it_hdr;
  logic [2:0]       it_pad;
  logic [LEN_W-1:0] it_len;
  logic [BW-1:0]    it_bits;

  assign {it_hdr, it_pad, it_len, it_bits} = q_item_i;

  assign slot_free = !out_valid_q || !out_stall_i;

  // The buffer holds acc_len_q bits right-aligned; bits above them stay zero.
  always_comb begin
    acc_d      = acc_q;
    acc_len_d  = acc_len_q;
    emit       = 1'b0;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    q_pop_o    = 1'b0;
    left       = acc_len_q - AL_W'(BYTE_BITS);
    shifted    = acc_q >> left;
    if (acc_len_q >= AL_W'(BYTE_BITS)) begin
      if (slot_free) begin
        emit       = 1'b1;
        out_byte_d = shifted[7:0];
        out_last_d = (left < AL_W'(BYTE_BITS));
        acc_len_d  = left;
        acc_d      = acc_q & ~({W{1'b1}} << left);
      end
    end else if (q_valid_i && (!it_hdr || slot_free)) begin
      q_pop_o   = 1'b1;
      acc_d     = (acc_q << it_len) | W'(it_bits);
      acc_len_d = acc_len_q + AL_W'(it_len);
      if (it_hdr) begin
        // The header always has codeword bytes behind it, so it is never last.
        emit       = 1'b1;
        out_byte_d = {5'b00000, it_pad};
        out_last_d = 1'b0;
      end
    end
    out_valid_d = slot_free ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_len_q   <= acc_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

FILE: rtl/ccp_checker.sv
// Port-level checker of the CRC codeword packer and its bind statement.
`include "crc_codeword_packer_defines.svh"

module ccp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o
);

  logic seen_in_q, seen_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q  <= 1'b0;
      seen_out_q <= 1'b0;
    end else begin
      seen_in_q  <= seen_in_q | (in_valid_i && !in_stall_o);
      seen_out_q <= seen_out_q | (out_valid_o && !out_stall_i);
    end
  end

  `CCP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(last_of_run_o), "stalled output changed")
  `CCP_ASSERT_NOW(a_no_early_out, out_valid_o, seen_in_q, "output before any input transfer")
  `CCP_ASSERT_NOW(a_header_first, out_valid_o && !seen_out_q, (out_byte_o < 8'd8) && !last_of_run_o, "first byte is not a header")

endmodule

bind crc_codeword_packer ccp_checker u_ccp_checker (.*);

FILE: verif/crc_codeword_packer_tb.sv
// Self-checking testbench of the CRC codeword packer: directed table, random phases, CRC predictor.
module crc_codeword_packer_tb import ccp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned RAND_PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 18;
  localparam int unsigned MAX_PRINTS  = 20;

  typedef struct packed {
    logic [7:0] ob;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic                        is_cfg;
    cfg_idx_e                    idx;
    logic [DEF_COUNT_BITS-1:0]   val;
    logic [7:0]                  data;
    logic [1:0]                  n_typed;
    logic [2:0][7:0]             typed;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [7:0]                data_byte_i = 8'h00;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [7:0]                out_byte_o;
  logic                      last_of_run_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  cfg_idx_e                  cfg_index_i = CFG_POLY;
  logic [DEF_COUNT_BITS-1:0] cfg_data_i = '0;

  // Predictor copy of the registers and of the packing state.
  logic [POLY_W-1:0]         gen_poly;
  logic [GLEN_W-1:0]         gen_len;
  logic                      dw_mode;
  logic [DEF_COUNT_BITS-1:0] msg_bytes;
  logic [7:0]                pack_acc;
  int unsigned               pack_cnt;
  bit                        header_done;

  logic [7:0]  run_bytes[$];
  out_item_t   exp_out_q[$];
  out_item_t   head_exp;
  stim_row_t   dir_tab[$];

  int unsigned cyc;
  int unsigned err_cnt;
  int unsigned bytes_in;
  int unsigned bytes_out;
  int unsigned cfg_phases;
  bit          hold_req;
  bit          hold_active;
  bit          hold_done;

  crc_codeword_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc++;
    if (cyc == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) begin
      $display("MISMATCH cycle %0d: %s", cyc, msg);
    end
    err_cnt++;
  endtask

  function automatic void pack_bit(input logic b);
    pack_acc = {pack_acc[6:0], b};
    pack_cnt++;
    if (pack_cnt == BYTE_BITS) begin
      run_bytes.push_back(pack_acc);
      pack_acc = '0;
      pack_cnt = 0;
    end
  endfunction

  // Shift-register division; the leading generator bit is implied.
  function automatic void append_codeword(input logic [7:0] word, input int unsigned width,
                                          input int unsigned r);
    logic [15:0] mask;
    logic [15:0] rem;
    logic        top;
    logic        din;
    int unsigned i;
    mask = (16'd1 << r) - 16'd1;
    rem  = '0;
    for (i = 0; i < width + r; i++) begin
      din = (i < width) ? word[width-1-i] : 1'b0;
      top = rem[r-1];
      rem = ((rem << 1) | 16'(din)) & mask;
      if (top) rem ^= gen_poly & mask;
    end
    for (i = 0; i < width; i++) pack_bit(word[width-1-i]);
    for (i = 0; i < r; i++) pack_bit(rem[r-1-i]);
  endfunction

  function automatic void predict_out_bytes(input logic [7:0] d);
    int unsigned r;
    int unsigned dw;
    int unsigned pad;
    logic [2:0]  words_lo;
    if (gen_len < 2) r = 1;
    else if (gen_len > DEF_MAX_GEN_BITS) r = DEF_MAX_GEN_BITS - 1;
    else r = gen_len - 1;
    dw = (dw_mode == MODE_BYTE) ? BYTE_BITS : NIBBLE_BITS;
    run_bytes.delete();
    if (!header_done) begin
      // Only the message length modulo eight decides the pad count.
      words_lo = (dw_mode == MODE_BYTE) ? msg_bytes[2:0] : {msg_bytes[1:0], 1'b0};
      pad = (8 - ((dw + r) * int'(words_lo)) % 8) % 8;
      run_bytes.push_back(8'(pad));
      header_done = 1'b1;
      repeat (pad) pack_bit(1'b0);
    end
    if (dw_mode == MODE_BYTE) begin
      append_codeword(d, BYTE_BITS, r);
    end else begin
      append_codeword({4'h0, d[7:4]}, NIBBLE_BITS, r);
      append_codeword({4'h0, d[3:0]}, NIBBLE_BITS, r);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic stim_row_t cfg_row(input cfg_idx_e idx, input logic [23:0] val);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic stim_row_t data_row(input logic [7:0] d, input logic [1:0] n,
                                         input logic [2:0][7:0] typed);
    stim_row_t row;
    row         = '0;
    row.idx     = CFG_POLY;
    row.data    = d;
    row.n_typed = n;
    row.typed   = typed;
    return row;
  endfunction

  task automatic send_byte(input logic [7:0] d, input int unsigned gap,
                           input logic [1:0] n_typed, input logic [2:0][7:0] typed);
    int unsigned k;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    bytes_in++;
    predict_out_bytes(d);
    if (n_typed != 0) begin
      run_bytes.delete();
      for (k = 0; k < n_typed; k++) run_bytes.push_back(typed[k]);
    end
    for (k = 0; k < run_bytes.size(); k++) begin
      exp_out_q.push_back({run_bytes[k], k == run_bytes.size() - 1});
    end
  endtask

  // Registers change only once every predicted byte has been seen.
  task automatic cfg_write(input cfg_idx_e idx, input logic [DEF_COUNT_BITS-1:0] val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (exp_out_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_POLY:  gen_poly  = val[POLY_W-1:0];
      CFG_GLEN:  gen_len   = val[GLEN_W-1:0];
      CFG_MODE:  dw_mode   = val[0];
      CFG_TOTAL: msg_bytes = val;
      default:   ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_out++;
      if (exp_out_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h", out_byte_o));
      end else begin
        head_exp = exp_out_q.pop_front();
        if (out_byte_o !== head_exp.ob) begin
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, head_exp.ob));
        end
        if (last_of_run_o !== head_exp.last) begin
          report_mismatch($sformatf("last_of_run %b, want %b", last_of_run_o, head_exp.last));
        end
      end
    end
  end

  // Output back-pressure: random stalls, quiet stretches and one long hold-off.
  initial begin
    int unsigned roll;
    int unsigned span;
    int unsigned held;
    logic        level;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        hold_active = 1'b1;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 3) begin
          level = 1'b1;
          span  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          span  = (roll == 9) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        end
        @(negedge clk_i);
        out_stall_i <= level;
        repeat (span - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned ph;
    int unsigned n;
    bit          burst;
    logic [7:0]  d;
    int unsigned roll;

    gen_poly    = RST_POLY;
    gen_len     = RST_GLEN;
    dw_mode     = MODE_BYTE;
    msg_bytes   = '0;
    pack_acc    = '0;
    pack_cnt    = 0;
    header_done = 1'b0;

    // A three-byte message needs seven pad bits, so an all-zero first byte gives
    // the header and then two zero bytes.
    dir_tab.push_back(cfg_row(CFG_TOTAL, 24'd3));
    dir_tab.push_back(data_row(8'h00, 2'd3, {8'h00, 8'h00, 8'h07}));
    dir_tab.push_back(data_row(8'hFF, 2'd0, '0));
    dir_tab.push_back(data_row(8'h80, 2'd0, '0));
    dir_tab.push_back(data_row(8'h01, 2'd0, '0));
    dir_tab.push_back(data_row(8'hA5, 2'd0, '0));
    dir_tab.push_back(cfg_row(CFG_MODE, 24'(MODE_NIBBLE)));
    dir_tab.push_back(cfg_row(CFG_GLEN, 24'd16));
    dir_tab.push_back(cfg_row(CFG_POLY, 24'h00FFFF));
    dir_tab.push_back(data_row(8'h0F, 2'd0, '0));
    dir_tab.push_back(data_row(8'hF0, 2'd0, '0));
    dir_tab.push_back(data_row(8'h00, 2'd0, '0));
    dir_tab.push_back(data_row(8'hFF, 2'd0, '0));
    dir_tab.push_back(cfg_row(CFG_GLEN, 24'd2));
    dir_tab.push_back(cfg_row(CFG_POLY, 24'h000000));
    dir_tab.push_back(cfg_row(CFG_MODE, 24'(MODE_BYTE)));
    dir_tab.push_back(data_row(8'hFF, 2'd0, '0));
    dir_tab.push_back(data_row(8'h00, 2'd0, '0));
    dir_tab.push_back(data_row(8'h81, 2'd0, '0));
    // Lengths outside the legal span clamp to the nearest end.
    dir_tab.push_back(cfg_row(CFG_GLEN, 24'd0));
    dir_tab.push_back(cfg_row(CFG_POLY, 24'h000001));
    dir_tab.push_back(data_row(8'h7E, 2'd0, '0));
    dir_tab.push_back(data_row(8'h00, 2'd0, '0));
    dir_tab.push_back(cfg_row(CFG_GLEN, 24'd1));
    dir_tab.push_back(data_row(8'hC3, 2'd0, '0));
    dir_tab.push_back(cfg_row(CFG_GLEN, 24'd17));
    dir_tab.push_back(cfg_row(CFG_POLY, 24'h008005));
    dir_tab.push_back(cfg_row(CFG_MODE, 24'(MODE_NIBBLE)));
    dir_tab.push_back(data_row(8'h3C, 2'd0, '0));
    dir_tab.push_back(data_row(8'h00, 2'd0, '0));
    dir_tab.push_back(cfg_row(CFG_GLEN, 24'd31));
    dir_tab.push_back(cfg_row(CFG_TOTAL, 24'hFFFFFF));
    dir_tab.push_back(data_row(8'hFF, 2'd0, '0));
    dir_tab.push_back(data_row(8'h96, 2'd0, '0));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        cfg_write(row.idx, row.val);
        cfg_phases++;
      end else begin
        send_byte(row.data, pick_gap(), row.n_typed, row.typed);
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      // Upper data bits beyond each register's width are random on purpose.
      cfg_write(CFG_POLY, 24'($urandom()));
      roll = $urandom_range(0, 9);
      n    = (roll == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      cfg_write(CFG_GLEN, {19'($urandom()), 5'(n)});
      cfg_write(CFG_MODE, 24'($urandom()));
      cfg_write(CFG_TOTAL, 24'($urandom()));
      cfg_phases++;
      burst = ($urandom_range(0, 2) == 0);
      if (ph == 1) begin
        // Keep offering input while the output is held so the queue fills up.
        hold_req = 1'b1;
        burst    = 1'b1;
        while (!hold_active) @(posedge clk_i);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 7);
        if (roll == 0) d = 8'h00;
        else if (roll == 1) d = 8'hFF;
        else d = 8'($urandom_range(0, 255));
        send_byte(d, burst ? 0 : pick_gap(), 2'd0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (exp_out_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d input bytes over %0d register settings; checked %0d output bytes.",
             bytes_in, cfg_phases, bytes_out);
    $display("Both dataword modes, clamped generator lengths and one long output hold-off.");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
